### rtl/core/lfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int Entries   = 16;
  localparam int CountBits = 16;
  localparam int StampBits = 48;
  localparam int KeyBits   = 32;
  localparam int ValBits   = 32;
  localparam int IdxBits   = $clog2(Entries);
  localparam int CapBits   = $clog2(Entries + 1);

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } state_t;

  // One entry as it travels along the row of cells.
  typedef struct packed {
    logic                 valid;
    logic [KeyBits-1:0]   key;
    logic [ValBits-1:0]   value;
    logic [CountBits-1:0] count;
    logic [StampBits-1:0] stamp;
  } slot_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic                 shift;
    logic                 write;
    logic [IdxBits-1:0]   wr_idx;
    slot_t                wr_slot;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/lfu_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cell
// One cache slot. During a scan the row rotates, each cell passing its
// entry to its neighbor, so slot 0's position sees every entry in turn.
// ----------------------------------------------------------------------------
module lfu_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [lfu_pkg::IdxBits-1:0] my_idx,
  input  wire lfu_pkg::cell_ctl_t ctl,
  input  wire lfu_pkg::slot_t    from_next,
  output lfu_pkg::slot_t         held
);
  import lfu_pkg::*;

  slot_t data;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= from_next;
    end else if (ctl.write && ctl.wr_idx == my_idx) begin
      data <= ctl.wr_slot;
    end
    if (rst) begin
      data.valid <= 1'b0;
    end
  end

  assign held = data;

endmodule
`default_nettype wire

### rtl/core/lfu_cache_lru_tiebreak.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// Fully associative cache, LFU replacement with LRU tie-break, built as a
// rotating row of slot cells and a scan sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid, in_stall, func, lookup_key,| into block
//          | write_value                          |
//  out     | out_valid, out_stall, hit, read_value| out of block
//  cfg     | cfg_valid, cfg_ready, entries_in_use | into block
//
// Each item passes through an accept step, a scan in which the row rotates
// a full turn past the compare logic at slot 0, and an apply step; a get
// adds an output state that holds its result in the output register.
// Reset is synchronous and clears valid bits, fill count and access counter.
// A stalled result blocks the next item until it is transferred.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [31:0] lookup_key,
  input  wire logic signed [31:0] write_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             hit,
  output logic signed [31:0] read_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  entries_in_use
);
  import lfu_pkg::*;

  state_t state, state_next;
  logic [4:0] cap_reg;
  logic [CapBits-1:0] cap;
  logic [CapBits-1:0] filled;
  logic [StampBits-1:0] acc;
  logic [IdxBits:0] step;
  logic op;
  logic [KeyBits-1:0] key;
  logic [ValBits-1:0] val;
  logic found;
  logic [IdxBits-1:0] found_idx;
  logic [IdxBits-1:0] vic_idx;
  logic [CountBits-1:0] vic_count;
  logic [StampBits-1:0] vic_stamp;
  logic vic_any;
  slot_t found_slot;

  slot_t     row [Entries];
  cell_ctl_t ctl;

  for (genvar g = 0; g < Entries; g++) begin : g_cell
    lfu_cell u_cell (
      .clk(clk), .rst(rst), .my_idx(IdxBits'(g)), .ctl(ctl),
      .from_next(row[(g + 1) % Entries]), .held(row[g])
    );
  end

  assign cap = (cap_reg > 5'(Entries)) ? CapBits'(Entries) : CapBits'(cap_reg);
  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);

  // Original index of the entry now at position 0 is the step count.
  logic [IdxBits-1:0] cur_idx;
  logic cur_in;
  slot_t cur;
  assign cur_idx = step[IdxBits-1:0];
  assign cur = row[0];
  assign cur_in = ({1'b0, step} < (IdxBits+2)'(cap));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cap_reg <= 5'(Entries);
      filled  <= '0;
      acc     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) cap_reg <= entries_in_use;
      if (state == ST_IDLE && in_valid) begin
        acc <= acc + 1'b1;
        op <= func; key <= lookup_key; val <= write_value;
        step <= '0; found <= 1'b0; vic_any <= 1'b0;
      end
      if (state == ST_SCAN) begin
        step <= step + 1'b1;
        if (cur_in && cur.valid && cur.key == key && !found) begin
          found <= 1'b1; found_idx <= cur_idx; found_slot <= cur;
        end
        if (cur_in && (!vic_any || cur.count < vic_count ||
            (cur.count == vic_count && cur.stamp < vic_stamp))) begin
          vic_any <= 1'b1; vic_idx <= cur_idx;
          vic_count <= cur.count; vic_stamp <= cur.stamp;
        end
      end
      if (state == ST_APPLY) begin
        if (op == FUNC_PUT && cap != '0 && !found && filled < cap)
          filled <= filled + 1'b1;
        if (op == FUNC_GET) begin
          out_valid <= 1'b1;
          hit <= found;
          read_value <= found ? found_slot.value : '1;
        end
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        ctl.shift = 1'b1;
        if (step == (IdxBits+1)'(Entries - 1)) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        state_next = (op == FUNC_GET) ? ST_OUT : ST_IDLE;
        ctl.wr_slot.valid = 1'b1;
        ctl.wr_slot.stamp = acc;
        if (found) begin
          ctl.write = 1'b1;
          ctl.wr_idx = found_idx;
          ctl.wr_slot.key = found_slot.key;
          ctl.wr_slot.value = (op == FUNC_PUT) ? val : found_slot.value;
          ctl.wr_slot.count = found_slot.count + CountBits'(~&found_slot.count);
        end else if (op == FUNC_PUT && cap != '0) begin
          ctl.write = 1'b1;
          ctl.wr_idx = (filled < cap) ? filled[IdxBits-1:0] : vic_idx;
          ctl.wr_slot.key = key;
          ctl.wr_slot.value = val;
          ctl.wr_slot.count = CountBits'(1);
        end
      end
      ST_OUT: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    filled <= CapBits'(Entries)) else $error("fill count beyond slots");
  a_get_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && op == FUNC_GET) |=> out_valid)
    else $error("get without result");

endmodule
`default_nettype wire

### verif/tb_lfu_cache_lru_tiebreak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfu_cache_lru_tiebreak
// Drives gets and puts into the LFU cache and checks every get result against
// a behavioral copy of the cache kept in the bench.
// ----------------------------------------------------------------------------
module tb_lfu_cache_lru_tiebreak;
  import lfu_pkg::*;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] wval;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] rval;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_GET;
  logic [31:0] lookup_key = '0;
  logic signed [31:0] write_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic signed [31:0] read_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  entries_in_use = 5'd16;

  lfu_cache_lru_tiebreak i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .lookup_key(lookup_key), .write_value(write_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .read_value(read_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .entries_in_use(entries_in_use)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the cache.
  logic [KeyBits-1:0]   m_key   [Entries];
  logic [ValBits-1:0]   m_val   [Entries];
  logic [CountBits-1:0] m_count [Entries];
  logic [StampBits-1:0] m_stamp [Entries];
  logic                 m_valid [Entries];
  int unsigned          m_filled;
  logic [StampBits-1:0] m_clock;
  logic [4:0]           m_cap_reg;

  access_t pending_q[$];
  lookup_t lookup_q[$];
  int      errors = 0;
  int      gets_seen = 0;
  int      hits_seen = 0;
  int      puts_sent = 0;

  function automatic void cache_reset();
    for (int i = 0; i < Entries; i++) m_valid[i] = 1'b0;
    m_filled = 0;
    m_clock = '0;
    m_cap_reg = 5'd16;
  endfunction

  function automatic void cache_access(access_t a);
    int cap;
    int s;
    int v;
    cap = (m_cap_reg > Entries) ? Entries : m_cap_reg;
    s = -1;
    v = 0;
    m_clock = m_clock + 1'b1;
    for (int i = 0; i < cap; i++)
      if (s < 0 && m_valid[i] && m_key[i] == a.key) s = i;
    if (s >= 0 && (a.op == FUNC_GET || cap != 0)) begin
      if (m_count[s] != '1) m_count[s] = m_count[s] + 1'b1;
      m_stamp[s] = m_clock;
    end
    if (a.op == FUNC_GET) begin
      lookup_q.push_back(s >= 0 ? lookup_t'{1'b1, m_val[s]} : lookup_t'{1'b0, 32'hFFFF_FFFF});
    end else if (cap != 0) begin
      if (s >= 0) begin
        m_val[s] = a.wval;
      end else begin
        if (m_filled < cap) begin
          v = m_filled;
          m_filled++;
        end else begin
          for (int j = 1; j < cap; j++)
            if (m_count[j] < m_count[v] ||
                (m_count[j] == m_count[v] && m_stamp[j] < m_stamp[v])) v = j;
        end
        m_key[v] = a.key;
        m_val[v] = a.wval;
        m_count[v] = CountBits'(1);
        m_stamp[v] = m_clock;
        m_valid[v] = 1'b1;
      end
    end
  endfunction

  // Driver: one item on the bus at a time, with a random gap before each.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        cache_access(access_t'{func, lookup_key, write_value});
        if (func == FUNC_PUT) puts_sent++;
        void'(pending_q.pop_front());
        in_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
        in_valid <= 1'b0;
      end else if (!in_valid && pending_q.size() != 0) begin
        if (in_gap > 0) begin
          in_gap--;
        end else begin
          in_valid    <= 1'b1;
          func        <= pending_q[0].op;
          lookup_key  <= pending_q[0].key;
          write_value <= pending_q[0].wval;
        end
      end
    end
  end

  // Monitor: checks results and throttles the output with random stalls.
  int out_hold = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        gets_seen++;
        if (hit) hits_seen++;
        if (lookup_q.size() == 0) begin
          $display("%0t: result with none expected: hit %0b value %0h", $time, hit, read_value);
          errors++;
        end else begin
          if (hit !== lookup_q[0].hit || read_value !== lookup_q[0].rval) begin
            $display("%0t: mismatch expected hit %0b value %0h, actual hit %0b value %0h",
                     $time, lookup_q[0].hit, lookup_q[0].rval, hit, read_value);
            errors++;
          end
          void'(lookup_q.pop_front());
        end
        out_hold = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) out_hold = 0;
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || lookup_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    @(posedge clk);
    cfg_valid      <= 1'b1;
    entries_in_use <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m_cap_reg = cap;
  endtask

  function automatic void add(logic op, logic [31:0] key, logic [31:0] wval);
    pending_q.push_back(access_t'{op, key, wval});
  endfunction

  // Random phase: keys from a narrow pool so that hits and evictions happen.
  task automatic random_phase(int n, int pool);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add(1'($urandom_range(0, 1)), $urandom, $urandom);
      else
        add(1'($urandom_range(0, 1)), base ^ $urandom_range(0, pool - 1), $urandom);
    end
    drain();
  endtask

  initial begin
    cache_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme keys and values, all-ones key, misses, updates.
    add(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    add(FUNC_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    add(FUNC_PUT, 32'h0, 32'h8000_0000);
    add(FUNC_GET, 32'h0, 32'hFFFF_FFFF);
    add(FUNC_PUT, 32'h0, 32'hFFFF_FFFF);
    add(FUNC_GET, 32'h0, 32'h0);
    add(FUNC_GET, 32'h1234_5678, 32'h0);
    for (int i = 0; i < 16; i++) add(FUNC_PUT, 32'h100 + i, i);
    add(FUNC_PUT, 32'hAAAA_5555, 32'h5555_AAAA);
    add(FUNC_GET, 32'h100, 32'h0);
    drain();

    // Lower capacity with slots hidden above it, then raise it again;
    // this also creates duplicate keys.
    write_capacity(5'd3);
    random_phase(300, 6);
    write_capacity(5'd0);
    random_phase(60, 4);
    write_capacity(5'd31);
    random_phase(400, 24);
    write_capacity(5'd1);
    random_phase(200, 3);
    write_capacity(5'd16);
    random_phase(500, 20);
    write_capacity(5'd7);
    random_phase(300, 10);
    write_capacity(5'd17);
    random_phase(250, 40);

    $display("Covered %0d gets (%0d hits) and %0d puts over capacities 0 to 31.",
             gets_seen, hits_seen, puts_sent);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d items still queued.", pending_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
